>>> src/ole_pkg.sv
// Package for the ordered list editor: operation, status and state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ole_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_APPEND  = 3'd1,
    OP_SORTED  = 3'd2,
    OP_BEFORE  = 3'd3,
    OP_DELETE  = 3'd4,
    OP_REPLACE = 3'd5,
    OP_READ    = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // SEARCH: scan for position, SHIFT: move entries up, COMPACT: delete sweep,
  // REPL: replace sweep, RDWAIT: read latency, DONE: result held
  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_SEARCH  = 3'd1,
    S_SHIFT   = 3'd2,
    S_COMPACT = 3'd3,
    S_REPL    = 3'd4,
    S_RDWAIT  = 3'd5,
    S_DONE    = 3'd6
  } state_t;

endpackage
`default_nettype wire

>>> src/ole_ram.sv
// Single-port-write, single-read entry store with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module ole_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/ordered_list_editor.sv
// Ordered list editor top level: sequencer, one shared compare unit, entry store.
// Depends on ole_pkg and ole_ram.
//
//  channel | dir | tdata fields (low bit up)               | tuser
//  in_     | in  | op[2:0] key[34:3] value[66:35] idx[72:67] | -
//  out_    | out | status[1:0] length[8:2] data[40:9] aff[47:41] | -
//
// Transaction steps: insert-before scans for the position, then shifts; sorted
// insert compares the tail entry, scans and shifts (one entry a cycle through
// the single store read port). Append and any insert into an empty list skip
// the scan; delete and replace sweep the list once; clear, unused op, refused
// insert and out-of-range read finish without touching the store.
// Reset clears the length and the sequencer; entries stay undefined.
// in_tready is high only when idle; a finished result holds in the output
// register until taken, and the next transaction can be taken in that cycle.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_editor #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,  // op, match_key, new_value, read_index
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata  // status, length, read_data, affected
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  ole_pkg::state_t state_r, state_nxt;
  ole_pkg::op_t    op_r;
  logic [31:0] key_r, val_r;
  logic [CW-1:0] cnt_r, cnt_nxt;      // entry count
  logic [CW-1:0] ri_r, ri_nxt;        // read pointer
  logic [CW-1:0] wi_r, wi_nxt;        // write pointer / position
  logic [CW-1:0] aff_r, aff_nxt;
  logic          pend_r, pend_nxt;    // read data valid for ri_r-1
  logic          tdone_r, tdone_nxt;  // tail entry already compared
  logic          tge_r, tge_nxt;      // new value at least the tail entry
  logic [1:0]    st_r, st_nxt;
  logic [31:0]   rd_r, rd_nxt;
  logic          ov_r;
  logic [47:0]   od_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  ole_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // shared compare unit: equality and signed less-than against the store word
  logic [31:0] cmp_a;
  logic        eq_w, lt_w;
  assign eq_w = (rdata == key_r);
  assign lt_w = ($signed(cmp_a) < $signed(rdata));
  assign cmp_a = val_r;

  logic accept_w;
  assign in_tready = (state_r == ole_pkg::S_IDLE) && (!ov_r || out_tready);
  assign accept_w  = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; ri_nxt = ri_r; wi_nxt = wi_r; aff_nxt = aff_r;
    pend_nxt = 1'b0; st_nxt = st_r; rd_nxt = rd_r;
    tdone_nxt = tdone_r; tge_nxt = tge_r;
    we = 1'b0; waddr = wi_r[AW-1:0]; wdata = val_r;
    raddr = ri_r[AW-1:0];
    case (state_r)
      ole_pkg::S_IDLE: begin
        if (accept_w) begin
          st_nxt = ole_pkg::ST_OK; rd_nxt = '0; aff_nxt = '0;
          ri_nxt = '0; wi_nxt = '0; tdone_nxt = 1'b0;
          state_nxt = ole_pkg::S_DONE;
          case (ole_pkg::op_t'(in_tdata[2:0]))
            ole_pkg::OP_CLEAR: cnt_nxt = '0;
            ole_pkg::OP_APPEND, ole_pkg::OP_SORTED, ole_pkg::OP_BEFORE: begin
              if (cnt_r >= CW'(CAPACITY)) begin
                st_nxt = ole_pkg::ST_FULL;
              end else begin
                state_nxt = ole_pkg::S_SEARCH;
              end
            end
            ole_pkg::OP_DELETE:  state_nxt = ole_pkg::S_COMPACT;
            ole_pkg::OP_REPLACE: state_nxt = ole_pkg::S_REPL;
            ole_pkg::OP_READ: begin
              if (32'(in_tdata[72:67]) < 32'(cnt_r)) begin
                ri_nxt = CW'(in_tdata[72:67]);
                state_nxt = ole_pkg::S_RDWAIT;
              end else begin
                st_nxt = ole_pkg::ST_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      ole_pkg::S_RDWAIT: begin
        // address registered into store this cycle; data next
        if (!pend_r) begin
          pend_nxt = 1'b1;
        end else begin
          rd_nxt = rdata;
          state_nxt = ole_pkg::S_DONE;
        end
      end
      ole_pkg::S_SEARCH: begin
        // find insert position wi; sequential read ri; sorted insert
        // compares against the tail entry before the scan
        if (op_r == ole_pkg::OP_APPEND || cnt_r == '0) begin
          wi_nxt = (op_r == ole_pkg::OP_APPEND) ? cnt_r : '0;
          ri_nxt = cnt_r;
          state_nxt = ole_pkg::S_SHIFT;
        end else if (op_r == ole_pkg::OP_SORTED && !tdone_r) begin
          if (!pend_r) begin
            raddr = AW'(cnt_r - 1'b1); pend_nxt = 1'b1;
          end else begin
            tge_nxt = !lt_w; tdone_nxt = 1'b1;
          end
        end else if (pend_r) begin
          if ((op_r == ole_pkg::OP_BEFORE && eq_w) ||
              (op_r == ole_pkg::OP_SORTED && lt_w)) begin
            wi_nxt = ri_r - 1'b1;
            ri_nxt = cnt_r;
            state_nxt = ole_pkg::S_SHIFT;
          end else if (ri_r == cnt_r || (op_r == ole_pkg::OP_SORTED && tge_r)) begin
            // no match, or not below the front but at least the tail: append
            wi_nxt = cnt_r;
            ri_nxt = cnt_r;
            state_nxt = ole_pkg::S_SHIFT;
          end else begin
            ri_nxt = ri_r + 1'b1; pend_nxt = 1'b1;
          end
        end else begin
          ri_nxt = ri_r + 1'b1; pend_nxt = 1'b1;
        end
      end
      ole_pkg::S_SHIFT: begin
        // ri walks down from cnt to wi+1, copying entry ri-1 to ri
        if (ri_r == wi_r) begin
          if (!pend_r) begin
            we = 1'b1; waddr = wi_r[AW-1:0]; wdata = val_r;
            cnt_nxt = cnt_r + 1'b1; aff_nxt = CW'(1);
            state_nxt = ole_pkg::S_DONE;
          end else begin
            pend_nxt = 1'b0;
          end
        end else if (!pend_r) begin
          raddr = AW'(ri_r - 1'b1); pend_nxt = 1'b1;
        end else begin
          we = 1'b1; waddr = ri_r[AW-1:0]; wdata = rdata;
          ri_nxt = ri_r - 1'b1;
          if (ri_r - 1'b1 == wi_r) begin
            pend_nxt = 1'b0;
          end else begin
            raddr = AW'(ri_r - 2'd2); pend_nxt = 1'b1;
          end
        end
      end
      ole_pkg::S_COMPACT, ole_pkg::S_REPL: begin
        if (pend_r) begin
          if (eq_w) begin
            aff_nxt = aff_r + 1'b1;
            if (state_r == ole_pkg::S_REPL) begin
              we = 1'b1; waddr = AW'(ri_r - 1'b1); wdata = val_r;
            end
          end else if (state_r == ole_pkg::S_COMPACT) begin
            we = 1'b1; waddr = wi_r[AW-1:0]; wdata = rdata;
            wi_nxt = wi_r + 1'b1;
          end
        end
        if (ri_r == cnt_r) begin
          if (state_r == ole_pkg::S_COMPACT) begin
            cnt_nxt = (pend_r && !eq_w) ? wi_r + 1'b1 : wi_r;
          end
          state_nxt = ole_pkg::S_DONE;
        end else begin
          ri_nxt = ri_r + 1'b1; pend_nxt = 1'b1;
        end
      end
      ole_pkg::S_DONE: state_nxt = ole_pkg::S_IDLE;
      default: state_nxt = ole_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ole_pkg::S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      if (state_r == ole_pkg::S_DONE) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ri_r <= ri_nxt; wi_r <= wi_nxt; aff_r <= aff_nxt;
    tdone_r <= tdone_nxt; tge_r <= tge_nxt;
    st_r <= st_nxt; rd_r <= rd_nxt;
    if (accept_w) begin
      op_r  <= ole_pkg::op_t'(in_tdata[2:0]);
      key_r <= in_tdata[34:3];
      val_r <= in_tdata[66:35];
    end
    if (state_r == ole_pkg::S_DONE) begin
      od_r <= {7'(aff_r), rd_r, 7'(cnt_r), st_r};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // an accepted transaction never overlaps an undelivered result slot
  assert property (@(posedge clk) disable iff (!rst_n)
    accept_w |-> (!ov_r || out_tready))
    else $error("accept while result blocked");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ole_pkg::S_SHIFT) |-> (wi_r <= ri_r))
    else $error("shift pointer below insert position");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ole_pkg::S_IDLE) |-> !in_tready)
    else $error("ready while busy");
endmodule
`default_nettype wire
